[hw/rtl/mscs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Marching squares cell segment package
// Case code weights, special case codes and edge identifiers shared by the
// cell segment unit.
// ----------------------------------------------------------------------------
package mscs_pkg;

   // Corner weights in the 4-bit case code.
   localparam logic [3:0] WEIGHT_TOP_LEFT     = 4'd8;
   localparam logic [3:0] WEIGHT_TOP_RIGHT    = 4'd4;
   localparam logic [3:0] WEIGHT_BOTTOM_RIGHT = 4'd2;
   localparam logic [3:0] WEIGHT_BOTTOM_LEFT  = 4'd1;

   // Case codes that need special handling.
   localparam logic [3:0] CODE_EMPTY    = 4'd0;
   localparam logic [3:0] CODE_SADDLE_A = 4'd5;
   localparam logic [3:0] CODE_SADDLE_B = 4'd10;
   localparam logic [3:0] CODE_FULL     = 4'd15;

   // Cell edges in examination order.
   typedef enum logic [1:0] {
      EDGE_LEFT   = 2'd0,
      EDGE_TOP    = 2'd1,
      EDGE_RIGHT  = 2'd2,
      EDGE_BOTTOM = 2'd3
   } edge_id_type;

endpackage
`default_nettype wire

[hw/rtl/marching_squares_cell_segment_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Marching squares cell segment unit
// Turns one grid cell into at most one contour segment with interpolated,
// saturated end points.
// ----------------------------------------------------------------------------
// The unit accepts one cell word per cycle unless the output side stalls and
// returns its segment word through a register pipeline. The two restoring
// dividers retire one quotient bit per pipeline stage; around them sit an
// input stage (case code, edge choice, magnitudes), a multiply stage and an
// output stage (offset add and saturation). Cells whose corners all share a
// sign (codes 0 and 15) produce no word. A stall at the output holds the whole
// pipeline.
module marching_squares_cell_segment_unit #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire signed [VALUE_WIDTH-1:0] req_value_bottom_left,
   input  wire signed [VALUE_WIDTH-1:0] req_value_top_left,
   input  wire signed [VALUE_WIDTH-1:0] req_value_bottom_right,
   input  wire signed [VALUE_WIDTH-1:0] req_value_top_right,
   input  wire signed [VALUE_WIDTH-1:0] req_center_x,
   input  wire signed [VALUE_WIDTH-1:0] req_center_y,
   input  wire        [VALUE_WIDTH-2:0] req_half_edge,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic       [3:0]             rsp_case_code,
   output logic signed [VALUE_WIDTH-1:0] rsp_start_x,
   output logic signed [VALUE_WIDTH-1:0] rsp_start_y,
   output logic signed [VALUE_WIDTH-1:0] rsp_end_x,
   output logic signed [VALUE_WIDTH-1:0] rsp_end_y
);

   localparam int W = VALUE_WIDTH;

   logic adv;

   // ------------------------------------------------------------------------
   // Input stage: case code, edge choice, magnitudes and edge coordinates.
   // ------------------------------------------------------------------------
   logic [3:0] code_in;
   logic [3:0] hit;
   mscs_pkg::edge_id_type sel_in [0:1];
   logic keep_in;

   always_comb begin
      code_in = 4'd0;
      if (req_value_top_left > 0)     code_in = code_in | mscs_pkg::WEIGHT_TOP_LEFT;
      if (req_value_top_right > 0)    code_in = code_in | mscs_pkg::WEIGHT_TOP_RIGHT;
      if (req_value_bottom_right > 0) code_in = code_in | mscs_pkg::WEIGHT_BOTTOM_RIGHT;
      if (req_value_bottom_left > 0)  code_in = code_in | mscs_pkg::WEIGHT_BOTTOM_LEFT;
      hit[0] = code_in[0] != code_in[3];
      hit[1] = code_in[3] != code_in[2];
      hit[2] = code_in[1] != code_in[2];
      hit[3] = code_in[0] != code_in[1];
      keep_in = (code_in != mscs_pkg::CODE_EMPTY) && (code_in != mscs_pkg::CODE_FULL);
   end

   // Pick the two joined edges: saddles are fixed, else the first two crossings.
   always_comb begin
      if (code_in == mscs_pkg::CODE_SADDLE_A) begin
         sel_in[0] = mscs_pkg::EDGE_LEFT;
         sel_in[1] = mscs_pkg::EDGE_RIGHT;
      end else if (code_in == mscs_pkg::CODE_SADDLE_B) begin
         sel_in[0] = mscs_pkg::EDGE_TOP;
         sel_in[1] = mscs_pkg::EDGE_BOTTOM;
      end else if (hit[0]) begin
         sel_in[0] = mscs_pkg::EDGE_LEFT;
         sel_in[1] = hit[1] ? mscs_pkg::EDGE_TOP
                   : (hit[2] ? mscs_pkg::EDGE_RIGHT : mscs_pkg::EDGE_BOTTOM);
      end else if (hit[1]) begin
         sel_in[0] = mscs_pkg::EDGE_TOP;
         sel_in[1] = hit[2] ? mscs_pkg::EDGE_RIGHT : mscs_pkg::EDGE_BOTTOM;
      end else begin
         sel_in[0] = mscs_pkg::EDGE_RIGHT;
         sel_in[1] = mscs_pkg::EDGE_BOTTOM;
      end
   end

   logic [W-1:0]   h2_in;
   logic [W-1:0]   ma_in    [0:1];
   logic [W:0]     d_in     [0:1];
   logic [W-1:0]   fixed_in [0:1];
   logic signed [W:0] base_in [0:1];
   logic           ax_in    [0:1];

   always_comb begin
      h2_in = {req_half_edge, 1'b0};
   end

   // Per-lane edge geometry.
   for (genvar ln = 0; ln < 2; ln++) begin : g_lane_in
      logic signed [W-1:0] va, vb, c_along, c_fixed;
      logic                fixed_up;
      logic [W-1:0]        ma, mb;
      logic signed [W:0]   fx;
      always_comb begin
         case (sel_in[ln])
            mscs_pkg::EDGE_LEFT: begin
               va = req_value_bottom_left; vb = req_value_top_left;
               c_along = req_center_y; c_fixed = req_center_x; fixed_up = 1'b0;
               ax_in[ln] = 1'b0;
            end
            mscs_pkg::EDGE_TOP: begin
               va = req_value_top_left; vb = req_value_top_right;
               c_along = req_center_x; c_fixed = req_center_y; fixed_up = 1'b1;
               ax_in[ln] = 1'b1;
            end
            mscs_pkg::EDGE_RIGHT: begin
               va = req_value_bottom_right; vb = req_value_top_right;
               c_along = req_center_y; c_fixed = req_center_x; fixed_up = 1'b1;
               ax_in[ln] = 1'b0;
            end
            default: begin
               va = req_value_bottom_left; vb = req_value_bottom_right;
               c_along = req_center_x; c_fixed = req_center_y; fixed_up = 1'b0;
               ax_in[ln] = 1'b1;
            end
         endcase
         ma = va[W-1] ? (~va + 1'b1) : va;
         mb = vb[W-1] ? (~vb + 1'b1) : vb;
         ma_in[ln] = ma;
         d_in[ln]  = {1'b0, ma} + {1'b0, mb};
         base_in[ln] = {c_along[W-1], c_along} - $signed({2'b00, req_half_edge});
         fx = fixed_up ? ({c_fixed[W-1], c_fixed} + $signed({2'b00, req_half_edge}))
                       : ({c_fixed[W-1], c_fixed} - $signed({2'b00, req_half_edge}));
         // Saturate the fixed coordinate to the signed range.
         if (fx[W] != fx[W-1]) begin
            fixed_in[ln] = fx[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else begin
            fixed_in[ln] = fx[W-1:0];
         end
      end
   end

   // Stage 0 registers.
   logic           s0_valid_ff;
   logic [3:0]     s0_code_ff;
   logic [W-1:0]   s0_h2_ff;
   logic [W-1:0]   s0_ma_ff    [0:1];
   logic [W:0]     s0_d_ff     [0:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid && keep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_code_ff <= code_in;
         s0_h2_ff   <= h2_in;
         for (int ln = 0; ln < 2; ln++) begin
            s0_ma_ff[ln] <= ma_in[ln];
            s0_d_ff[ln]  <= d_in[ln];
         end
      end
   end

   // Sideband carried alongside the arithmetic: valid, code, geometry.
   // Valid and code start from the stage 0 registers, so their chain begins
   // at index 1, in step with the multiply register.
   logic           sb_valid_ff [1:W+1];
   logic [3:0]     sb_code_ff  [1:W+1];
   logic [W-1:0]   sb_fixed_ff [0:W+1][0:1];
   logic signed [W:0] sb_base_ff [0:W+1][0:1];
   logic           sb_ax_ff    [0:W+1][0:1];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ln = 0; ln < 2; ln++) begin
            sb_fixed_ff[0][ln] <= fixed_in[ln];
            sb_base_ff[0][ln]  <= base_in[ln];
            sb_ax_ff[0][ln]    <= ax_in[ln];
         end
         sb_code_ff[1] <= s0_code_ff;
         for (int s = 2; s <= W + 1; s++) begin
            sb_code_ff[s] <= sb_code_ff[s-1];
         end
         for (int s = 1; s <= W + 1; s++) begin
            for (int ln = 0; ln < 2; ln++) begin
               sb_fixed_ff[s][ln] <= sb_fixed_ff[s-1][ln];
               sb_base_ff[s][ln]  <= sb_base_ff[s-1][ln];
               sb_ax_ff[s][ln]    <= sb_ax_ff[s-1][ln];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= W + 1; s++) begin
            sb_valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         sb_valid_ff[1] <= s0_valid_ff;
         for (int s = 2; s <= W + 1; s++) begin
            sb_valid_ff[s] <= sb_valid_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Multiply stage: dividend 2h * |a|.
   // ------------------------------------------------------------------------
   logic [W:0]   rem_ff [0:W][0:1];
   logic [W-1:0] low_ff [0:W][0:1];
   logic [W-1:0] q_ff   [0:W][0:1];
   logic [W:0]   d_ff   [0:W][0:1];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ln = 0; ln < 2; ln++) begin
            logic [2*W-1:0] prod;
            prod = s0_h2_ff * s0_ma_ff[ln];
            rem_ff[0][ln] <= {1'b0, prod[2*W-1:W]};
            low_ff[0][ln] <= prod[W-1:0];
            q_ff[0][ln]   <= '0;
            d_ff[0][ln]   <= s0_d_ff[ln];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Divider stages: one restoring step per stage and lane.
   // ------------------------------------------------------------------------
   for (genvar s = 1; s <= W; s++) begin : g_div
      for (genvar ln = 0; ln < 2; ln++) begin : g_lane
         logic [W+1:0] shifted, diff;
         always_comb begin
            shifted = {rem_ff[s-1][ln], low_ff[s-1][ln][W-1]};
            diff    = shifted - {1'b0, d_ff[s-1][ln]};
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               if (shifted >= {1'b0, d_ff[s-1][ln]}) begin
                  rem_ff[s][ln] <= diff[W:0];
                  q_ff[s][ln]   <= {q_ff[s-1][ln][W-2:0], 1'b1};
               end else begin
                  rem_ff[s][ln] <= shifted[W:0];
                  q_ff[s][ln]   <= {q_ff[s-1][ln][W-2:0], 1'b0};
               end
               low_ff[s][ln] <= {low_ff[s-1][ln][W-2:0], 1'b0};
               d_ff[s][ln]   <= d_ff[s-1][ln];
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output stage: along coordinate = (center - h) + offset, saturated.
   // ------------------------------------------------------------------------
   logic [W-1:0] along_in [0:1];
   logic [W-1:0] px_in [0:1];
   logic [W-1:0] py_in [0:1];

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane_out
      logic signed [W+1:0] sum;
      always_comb begin
         sum = {sb_base_ff[W+1][ln][W], sb_base_ff[W+1][ln]}
             + $signed({2'b00, q_ff[W][ln]});
         if ((sum[W+1] != sum[W]) || (sum[W] != sum[W-1])) begin
            along_in[ln] = sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else begin
            along_in[ln] = sum[W-1:0];
         end
         if (sb_ax_ff[W+1][ln]) begin
            px_in[ln] = along_in[ln];
            py_in[ln] = sb_fixed_ff[W+1][ln];
         end else begin
            px_in[ln] = sb_fixed_ff[W+1][ln];
            py_in[ln] = along_in[ln];
         end
      end
   end

   logic         out_valid_ff;
   logic [3:0]   out_code_ff;
   logic [W-1:0] out_sx_ff, out_sy_ff, out_ex_ff, out_ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= sb_valid_ff[W+1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_code_ff <= sb_code_ff[W+1];
         out_sx_ff   <= px_in[0];
         out_sy_ff   <= py_in[0];
         out_ex_ff   <= px_in[1];
         out_ey_ff   <= py_in[1];
      end
   end

   // The pipeline moves whenever the output register is free or being taken.
   always_comb begin
      adv           = !out_valid_ff || rsp_ready;
      req_ready     = adv;
      rsp_valid     = out_valid_ff;
      rsp_case_code = out_code_ff;
      rsp_start_x   = out_sx_ff;
      rsp_start_y   = out_sy_ff;
      rsp_end_x     = out_ex_ff;
      rsp_end_y     = out_ey_ff;
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_no_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_case_code != mscs_pkg::CODE_EMPTY)
                 && (rsp_case_code != mscs_pkg::CODE_FULL))
      else $error("Word for a cell without crossings.");

   a_ready_tracks_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("Input ready does not follow output register state.");

   a_saddle_a_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_case_code == mscs_pkg::CODE_SADDLE_A) |-> rsp_start_x <= rsp_end_x)
      else $error("Saddle left/right points out of order.");

   a_saddle_b_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_case_code == mscs_pkg::CODE_SADDLE_B) |-> rsp_start_y >= rsp_end_y)
      else $error("Saddle top/bottom points out of order.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Output valid after reset.");

endmodule
`default_nettype wire

[tb/sv/tb_marching_squares_cell_segment_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Marching squares cell segment unit testbench
// Feeds directed and random grid cells through the valid/ready request side,
// predicts each segment word with an independent fixed-point predictor and
// checks every returned word in order, while both sides idle and stall.
// ----------------------------------------------------------------------------
module tb_marching_squares_cell_segment_unit;

   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;

   typedef struct {
      logic [3:0]        code;
      logic signed [31:0] sx, sy, ex, ey;
   } segment_type;

   // Segment prediction and in-order comparison.
   class segment_scoreboard;
      segment_type pending[$];
      int          errors = 0;

      function longint clamp(longint v);
         if (v > VMAX) return VMAX;
         if (v < VMIN) return VMIN;
         return v;
      endfunction

      // Saturated crossing coordinate along an edge from corner a towards corner b.
      function longint crossing(longint c, longint h, longint a, longint b);
         logic [127:0] num, den;
         longint       ma, mb, off;
         ma = a < 0 ? -a : a;
         mb = b < 0 ? -b : b;
         num = 128'(2 * h) * 128'(ma);
         den = 128'(ma + mb);
         off = longint'(num / den);
         return clamp(c - h + off);
      endfunction

      function void note_cell(logic signed [31:0] bl, tl, br, tr, cx, cy,
                              logic [30:0] he);
         segment_type s;
         longint      px[4], py[4], h;
         bit          hit[4];
         int          first, second, n;
         h = longint'(he);
         s.code = 4'd0;
         if (tl > 0) s.code += mscs_pkg::WEIGHT_TOP_LEFT;
         if (tr > 0) s.code += mscs_pkg::WEIGHT_TOP_RIGHT;
         if (br > 0) s.code += mscs_pkg::WEIGHT_BOTTOM_RIGHT;
         if (bl > 0) s.code += mscs_pkg::WEIGHT_BOTTOM_LEFT;
         if (s.code == mscs_pkg::CODE_EMPTY || s.code == mscs_pkg::CODE_FULL) return;
         hit[mscs_pkg::EDGE_LEFT]   = (bl > 0) != (tl > 0);
         hit[mscs_pkg::EDGE_TOP]    = (tl > 0) != (tr > 0);
         hit[mscs_pkg::EDGE_RIGHT]  = (br > 0) != (tr > 0);
         hit[mscs_pkg::EDGE_BOTTOM] = (bl > 0) != (br > 0);
         px[mscs_pkg::EDGE_LEFT]   = clamp(cx - h);
         py[mscs_pkg::EDGE_LEFT]   = crossing(cy, h, bl, tl);
         px[mscs_pkg::EDGE_TOP]    = crossing(cx, h, tl, tr);
         py[mscs_pkg::EDGE_TOP]    = clamp(cy + h);
         px[mscs_pkg::EDGE_RIGHT]  = clamp(cx + h);
         py[mscs_pkg::EDGE_RIGHT]  = crossing(cy, h, br, tr);
         px[mscs_pkg::EDGE_BOTTOM] = crossing(cx, h, bl, br);
         py[mscs_pkg::EDGE_BOTTOM] = clamp(cy - h);
         if (s.code == mscs_pkg::CODE_SADDLE_A) begin
            first = mscs_pkg::EDGE_LEFT; second = mscs_pkg::EDGE_RIGHT;
         end else if (s.code == mscs_pkg::CODE_SADDLE_B) begin
            first = mscs_pkg::EDGE_TOP; second = mscs_pkg::EDGE_BOTTOM;
         end else begin
            n = 0; first = 0; second = 0;
            for (int k = 0; k < 4; k++) begin
               if (hit[k] && n == 1) begin second = k; n = 2; end
               if (hit[k] && n == 0) begin first = k; n = 1; end
            end
         end
         s.sx = 32'(px[first]); s.sy = 32'(py[first]);
         s.ex = 32'(px[second]); s.ey = 32'(py[second]);
         pending.push_back(s);
      endfunction

      function void check_segment(segment_type got);
         segment_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected segment word, code %0d", $time, got.code);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.code != want.code) begin
            $display("%0t: case_code expected %0d actual %0d", $time, want.code, got.code);
            errors++;
         end
         if (got.sx != want.sx) begin
            $display("%0t: start_x expected %0d actual %0d", $time, want.sx, got.sx);
            errors++;
         end
         if (got.sy != want.sy) begin
            $display("%0t: start_y expected %0d actual %0d", $time, want.sy, got.sy);
            errors++;
         end
         if (got.ex != want.ex) begin
            $display("%0t: end_x expected %0d actual %0d", $time, want.ex, got.ex);
            errors++;
         end
         if (got.ey != want.ey) begin
            $display("%0t: end_y expected %0d actual %0d", $time, want.ey, got.ey);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_bl = '0, req_tl = '0, req_br = '0, req_tr = '0;
   logic signed [31:0] req_cx = '0, req_cy = '0;
   logic [30:0] req_he = 31'd1;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_case_code;
   logic signed [31:0] rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic holdoff = 1'b0;
   bit   drain_done = 1'b0;

   segment_scoreboard sb = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   marching_squares_cell_segment_unit #(.VALUE_WIDTH(32), .FRAC_BITS(16)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_value_bottom_left(req_bl), .req_value_top_left(req_tl),
      .req_value_bottom_right(req_br), .req_value_top_right(req_tr),
      .req_center_x(req_cx), .req_center_y(req_cy), .req_half_edge(req_he),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_case_code(rsp_case_code), .rsp_start_x(rsp_start_x),
      .rsp_start_y(rsp_start_y), .rsp_end_x(rsp_end_x), .rsp_end_y(rsp_end_y)
   );

   // Result word check at each accepting edge.
   always @(posedge clock) begin
      segment_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.code = rsp_case_code;
         got.sx = rsp_start_x; got.sy = rsp_start_y;
         got.ex = rsp_end_x;   got.ey = rsp_end_y;
         sb.check_segment(got);
      end
   end

   // Receiver stall pattern, with one long hold-off on request.
   always @(posedge clock) begin
      int phase;
      phase = $urandom_range(0, 15);
      if (reset || holdoff) rsp_ready <= 1'b0;
      else if (drain_done) rsp_ready <= 1'b1;
      else rsp_ready <= phase < 11;
   end

   initial begin
      @(posedge clock);
      wait (!reset);
      repeat (150) @(posedge clock);
      holdoff <= 1'b1;
      repeat (300) @(posedge clock);
      holdoff <= 1'b0;
   end

   // Present one cell word and hold it until accepted.
   task automatic send_cell(logic signed [31:0] bl, tl, br, tr, cx, cy,
                            logic [30:0] he);
      req_valid <= 1'b1;
      req_bl <= bl; req_tl <= tl; req_br <= br; req_tr <= tr;
      req_cx <= cx; req_cy <= cy; req_he <= he;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_cell(bl, tl, br, tr, cx, cy, he);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'sd0;
         3: return $signed($urandom_range(0, 8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 4))
         0: return 32'sh7FFFFFF0 + $urandom_range(0, 15);
         1: return 32'sh80000000 + $urandom_range(0, 15);
         default: return $signed($urandom) >>> $urandom_range(0, 12);
      endcase
   endfunction

   function automatic logic [30:0] pick_half();
      case ($urandom_range(0, 4))
         0: return 31'h7FFFFFFF;
         1: return 31'd1;
         default: return 31'($urandom) >> $urandom_range(0, 20) | 31'd1;
      endcase
   endfunction

   initial begin
      int burst;
      logic [3:0] code;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cells: every case code, both saddles, extremes.
      for (int c = 0; c < 16; c++)
         send_cell(c[0] ? 32'sh10000 : -32'sh10000, c[3] ? 32'sh30000 : -32'sh8000,
                   c[1] ? 32'sh7FFFFFFF : 32'sh80000000, c[2] ? 32'sd1 : 32'sd0,
                   32'sh50000, -32'sh20000, 31'h10000);
      send_cell(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF);
      send_cell(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF);
      send_cell(32'sd1, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 31'd1);
      send_cell(32'sd0, 32'sd1, 32'sd0, 32'sd1, -32'sd1, 32'sd1, 31'd1);
      send_cell(32'shFFFFFFFF, 32'sd1, 32'sd1, 32'sd1, 32'sh7FFF0000,
                32'sh80010000, 31'h40000000);
      idle_gap(3);

      // Random bursts; most cells straddle zero so they yield a segment.
      for (int i = 0; i < 450; ) begin
         burst = $urandom_range(1, 20);
         for (int j = 0; j < burst && i < 450; j++, i++) begin
            code = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0)
               send_cell(pick_value(), pick_value(), pick_value(), pick_value(),
                         pick_coord(), pick_coord(), pick_half());
            else begin
               send_cell(code[0] ? 32'sd1 + ($urandom >> 1) : -($urandom >> 1),
                         code[3] ? 32'sd1 + ($urandom >> 1) : -($urandom >> 1),
                         code[1] ? 32'sd1 + ($urandom >> 2) : 32'sh80000000 | $urandom,
                         code[2] ? 32'sd1 + ($urandom_range(0, 9)) : -$urandom_range(0, 9),
                         pick_coord(), pick_coord(), pick_half());
            end
         end
         idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12));
      end
      req_valid <= 1'b0;
      drain_done = 1'b1;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
hw/rtl/mscs_pkg.sv
hw/rtl/marching_squares_cell_segment_unit.sv
tb/sv/tb_marching_squares_cell_segment_unit.sv
